>>> sv/cuwt_pkg.sv
// package for the card uid whitelist table
// op and status codes, field widths and parameter defaults
// no dependencies
package cuwt_pkg;

	// parameter defaults
	localparam int CUWT_MAX_ENTRIES = 32;
	localparam int CUWT_UID_BYTES   = 4;

	// field widths
	localparam int OP_W     = 3;
	localparam int UID_W    = 32;
	localparam int LEN_W    = 3;
	localparam int KIND_W   = 8;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_CHECK  = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

>>> sv/cuwt_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module cuwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/card_uid_whitelist_table_top.sv
// card uid whitelist table: add, remove, check, read and clear of uid entries
// uses cuwt_pkg and one cuwt_ram holding identifier, length and type per entry
//
// channel  dir  signals                 payload
// s        in   s_tvalid/s_tready       s_tdata: op, uid, uid_len, card_type, entry_index
// m        out  m_tvalid/m_tready       m_tdata: status, found, entry_count, read fields
//
// add, check and remove scan the stored entries through the ram read port, one entry
// a cycle; on a match remove then shifts the later entries down by one position, read
// fetches the indexed entry, and clear and rejected items finish without a ram access.
// reset empties the table by clearing the fill count; entries at or above it are never read.
// a new item is taken while the previous result still waits in the output register.
module card_uid_whitelist_table_top #(
	parameter int MAX_ENTRIES = cuwt_pkg::CUWT_MAX_ENTRIES,
	parameter int UID_BYTES   = cuwt_pkg::CUWT_UID_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[2:0], uid[34:3], uid_len[37:35], card_type[45:38], entry_index[51:46], zero pad
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], found[3], entry_count[9:4], read_uid[41:10], read_uid_len[44:42],
	// read_card_type[52:45], zero pad
	output logic [55:0] m_tdata
);

	import cuwt_pkg::*;

	localparam int USABLE = (UID_BYTES < 4) ? UID_BYTES : 4;
	localparam int IDW    = 8 * USABLE;
	localparam int DW     = IDW + LEN_W + KIND_W;
	localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW     = $clog2(MAX_ENTRIES + 1);
	localparam int XW     = (CW > IDX_W) ? CW : IDX_W;

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD_WAIT = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_SHIFT   = 3'd3;
	localparam logic [2:0] S_DONE    = 3'd4;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [IDW-1:0]      uid_q;
	logic [LEN_W-1:0]    len_q;
	logic [KIND_W-1:0]   kind_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rptr_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;

	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [UID_W-1:0]    res_uid_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [KIND_W-1:0]   res_kind_q;
	logic                m_tvalid_q;
	logic [55:0]         m_tdata_q;

	// input field split
	logic [OP_W-1:0]   in_op;
	logic [UID_W-1:0]  in_uid;
	logic [LEN_W-1:0]  in_len;
	logic [KIND_W-1:0] in_kind;
	logic [IDX_W-1:0]  in_idx;
	logic              in_accept;
	logic              in_len_ok;
	logic [XW-1:0]     idx_ext;
	logic [XW-1:0]     count_ext;
	logic              idx_in_range;

	assign in_op   = s_tdata[2:0];
	assign in_uid  = s_tdata[34:3];
	assign in_len  = s_tdata[37:35];
	assign in_kind = s_tdata[45:38];
	assign in_idx  = s_tdata[51:46];

	assign s_tready     = (state_q == S_IDLE);
	assign in_accept    = s_tvalid && s_tready;
	assign in_len_ok    = (in_len != '0) && (int'(in_len) <= USABLE);
	assign idx_ext      = XW'(in_idx);
	assign count_ext    = XW'(count_q);
	assign idx_in_range = (idx_ext < count_ext);

	// ram interface
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	cuwt_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ENTRIES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// compare of the entry read last cycle against the held key
	logic [IDW-1:0]    key_mask;
	logic [IDW-1:0]    rd_id;
	logic [LEN_W-1:0]  rd_len;
	logic [KIND_W-1:0] rd_kind;
	logic              hit;

	assign rd_id   = ram_rdata[IDW-1:0];
	assign rd_len  = ram_rdata[IDW +: LEN_W];
	assign rd_kind = ram_rdata[IDW+LEN_W +: KIND_W];

	always_comb begin
		for (int b = 0; b < USABLE; b++) begin
			key_mask[8*b +: 8] = {8{b < int'(len_q)}};
		end
	end

	assign hit = vld_s1 && (rd_len == len_q) && (((rd_id ^ uid_q) & key_mask) == '0);

	// scan and shift control
	logic more_reads;
	logic add_room;

	assign more_reads = (rptr_q < count_q);
	assign add_room   = (int'(count_q) < MAX_ENTRIES);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {kind_q, len_q, uid_q};
		unique case (state_q)
			S_IDLE: begin
				ram_re    = in_accept && (in_op == OP_READ) && idx_in_range;
				ram_raddr = idx_ext[AW-1:0];
			end
			S_SCAN: begin
				if (!hit && more_reads) begin
					ram_re = 1'b1;
				end
				if (!hit && !more_reads && (op_q == OP_ADD) && add_room) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT: begin
				ram_re    = more_reads;
				ram_we    = vld_s1;
				ram_waddr = addr_s1 - AW'(1);
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rptr_q  <= '0;
			vld_s1  <= 1'b0;
			addr_s1 <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						rptr_q <= '0;
						vld_s1 <= 1'b0;
						unique case (in_op) inside
							OP_ADD, OP_REMOVE, OP_CHECK: begin
								state_q <= in_len_ok ? S_SCAN : S_DONE;
							end
							OP_READ: begin
								state_q <= idx_in_range ? S_RD_WAIT : S_DONE;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						vld_s1 <= 1'b0;
						if (op_q == OP_REMOVE) begin
							rptr_q  <= CW'(addr_s1) + CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
					end else if (more_reads) begin
						vld_s1  <= 1'b1;
						addr_s1 <= rptr_q[AW-1:0];
						rptr_q  <= rptr_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if ((op_q == OP_ADD) && add_room) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (more_reads) begin
						vld_s1  <= 1'b1;
						addr_s1 <= rptr_q[AW-1:0];
						rptr_q  <= rptr_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// held item fields and result staging
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q        <= in_op;
			uid_q       <= in_uid[IDW-1:0];
			len_q       <= in_len;
			kind_q      <= in_kind;
			res_found_q <= 1'b0;
			res_uid_q   <= '0;
			res_len_q   <= '0;
			res_kind_q  <= '0;
			unique case (in_op) inside
				OP_ADD, OP_REMOVE, OP_CHECK: begin
					res_status_q <= in_len_ok ? ST_OK : ST_INVALID;
				end
				OP_READ: begin
					res_status_q <= idx_in_range ? ST_OK : ST_INVALID;
				end
				OP_CLEAR: begin
					res_status_q <= ST_OK;
				end
				default: begin
					res_status_q <= ST_INVALID;
				end
			endcase
		end else if (state_q == S_RD_WAIT) begin
			res_uid_q  <= UID_W'(rd_id);
			res_len_q  <= rd_len;
			res_kind_q <= rd_kind;
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				if (op_q == OP_ADD) begin
					res_status_q <= ST_EXISTS;
				end else if (op_q == OP_CHECK) begin
					res_found_q <= 1'b1;
				end
			end else if (!more_reads) begin
				if (op_q == OP_ADD) begin
					res_status_q <= add_room ? ST_OK : ST_FULL;
				end else begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
		end
	end

	// output register, loaded when the previous transfer is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {3'b000, res_kind_q, res_len_q, res_uid_q,
				count_ext[COUNT_W-1:0], res_found_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench for card_uid_whitelist_table_top: directed and random table operations
// predicts each response from its own copy of the table; depends on cuwt_pkg and the rtl
module tb;
	import cuwt_pkg::*;

	localparam int TABLE_DEPTH = CUWT_MAX_ENTRIES;
	localparam int USABLE_BYTES = (CUWT_UID_BYTES < 4) ? CUWT_UID_BYTES : 4;
	localparam int POOL_SIZE = 64;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [UID_W-1:0]  uid;
		logic [LEN_W-1:0]  uid_len;
		logic [KIND_W-1:0] card_type;
		logic [IDX_W-1:0]  entry_index;
	} table_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [COUNT_W-1:0]  entry_count;
		logic [UID_W-1:0]    read_uid;
		logic [LEN_W-1:0]    read_uid_len;
		logic [KIND_W-1:0]   read_card_type;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	// shadow copy of the whitelist
	logic [UID_W-1:0]  wl_ident [TABLE_DEPTH];
	logic [LEN_W-1:0]  wl_length [TABLE_DEPTH];
	logic [KIND_W-1:0] wl_kind [TABLE_DEPTH];
	int                wl_count;

	// identifiers reused by random traffic so that adds, removes and checks hit
	logic [UID_W-1:0] pool_uid [POOL_SIZE];
	logic [LEN_W-1:0] pool_len [POOL_SIZE];

	table_result_t pending_results[$];
	int            mismatch_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	card_uid_whitelist_table_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// byte mask for the first nbytes bytes of an identifier
	function automatic logic [UID_W-1:0] byte_mask(int nbytes);
		if (nbytes >= 4)
			return '1;
		return (32'd1 << (8 * nbytes)) - 32'd1;
	endfunction

	// position of the first stored entry matching uid and length, or -1
	function automatic int find_entry(logic [UID_W-1:0] uid, int len);
		logic [UID_W-1:0] mask;
		int i;
		mask = byte_mask(len);
		if (len == 0)
			return -1;
		for (i = 0; i < wl_count; i++) begin
			if (wl_length[i] == len && ((wl_ident[i] ^ uid) & mask) == '0)
				return i;
		end
		return -1;
	endfunction

	function automatic void wipe_table();
		int i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			wl_ident[i] = '0;
			wl_length[i] = '0;
			wl_kind[i] = '0;
		end
		wl_count = 0;
	endfunction

	// apply one operation to the shadow table and return the expected response
	function automatic table_result_t apply_table_op(table_req_t req);
		table_result_t res;
		logic [UID_W-1:0] uid;
		int len;
		int pos;
		int i;
		bit len_ok;
		res = '0;
		uid = req.uid & byte_mask(USABLE_BYTES);
		len = int'(req.uid_len);
		len_ok = (len != 0) && (len <= USABLE_BYTES);
		case (req.op)
			OP_ADD: begin
				if (!len_ok)
					res.status = ST_INVALID;
				else if (find_entry(uid, len) >= 0)
					res.status = ST_EXISTS;
				else if (wl_count >= TABLE_DEPTH)
					res.status = ST_FULL;
				else begin
					wl_ident[wl_count] = uid;
					wl_length[wl_count] = req.uid_len;
					wl_kind[wl_count] = req.card_type;
					wl_count++;
					res.status = ST_OK;
				end
			end
			OP_REMOVE: begin
				pos = find_entry(uid, len);
				if (!len_ok)
					res.status = ST_INVALID;
				else if (pos < 0)
					res.status = ST_NOT_FOUND;
				else begin
					for (i = pos; i + 1 < wl_count; i++) begin
						wl_ident[i] = wl_ident[i+1];
						wl_length[i] = wl_length[i+1];
						wl_kind[i] = wl_kind[i+1];
					end
					wl_count--;
					wl_ident[wl_count] = '0;
					wl_length[wl_count] = '0;
					wl_kind[wl_count] = '0;
					res.status = ST_OK;
				end
			end
			OP_CHECK: begin
				if (!len_ok)
					res.status = ST_INVALID;
				else if (find_entry(uid, len) >= 0) begin
					res.status = ST_OK;
					res.found = 1'b1;
				end else
					res.status = ST_NOT_FOUND;
			end
			OP_READ: begin
				if (req.entry_index >= wl_count)
					res.status = ST_INVALID;
				else begin
					res.status = ST_OK;
					res.read_uid = wl_ident[req.entry_index];
					res.read_uid_len = wl_length[req.entry_index];
					res.read_card_type = wl_kind[req.entry_index];
				end
			end
			OP_CLEAR: begin
				wipe_table();
				res.status = ST_OK;
			end
			default: res.status = ST_INVALID;
		endcase
		res.entry_count = COUNT_W'(wl_count);
		return res;
	endfunction

	// one transfer on the slave side; called between falling edges, returns at a falling edge
	task automatic send_op(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid,
			input logic [LEN_W-1:0] len, input logic [KIND_W-1:0] kind,
			input logic [IDX_W-1:0] idx);
		table_req_t req;
		req.op = op;
		req.uid = uid;
		req.uid_len = len;
		req.card_type = kind;
		req.entry_index = idx;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {4'b0000, req.entry_index, req.card_type, req.uid_len, req.uid, req.op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_table_op(req));
		@(negedge clk);
	endtask

	// drop valid and wait for every pending response plus the block's own latency
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v,
				act_v);
			mismatch_count++;
		end
	endtask

	// compare every response transfer with the oldest prediction
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %0h", $time,
					m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, m_tdata[2:0]);
				check_field("found", want.found, m_tdata[3]);
				check_field("entry_count", want.entry_count, m_tdata[9:4]);
				check_field("read_uid", want.read_uid, m_tdata[41:10]);
				check_field("read_uid_len", want.read_uid_len, m_tdata[44:42]);
				check_field("read_card_type", want.read_card_type, m_tdata[52:45]);
			end
		end
	end

	// field extremes, every operation and the corner cases of matching
	task automatic test_directed();
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd0);
		send_op(OP_CHECK, 32'h0000_0001, 3'd1, 8'h00, 6'd0);
		send_op(OP_REMOVE, 32'h0000_0001, 3'd1, 8'h00, 6'd0);
		send_op(OP_ADD, 32'h0000_0011, 3'd0, 8'h11, 6'd0);
		send_op(OP_ADD, 32'h0000_0011, 3'd5, 8'h11, 6'd0);
		send_op(OP_ADD, 32'h0000_0011, 3'd7, 8'h11, 6'd63);
		// a short identifier keeps its upper bytes
		send_op(OP_ADD, 32'hFFFF_FFFF, 3'd1, 8'hFF, 6'd0);
		send_op(OP_ADD, 32'h0000_00FF, 3'd1, 8'h01, 6'd0);
		send_op(OP_ADD, 32'h0000_00FF, 3'd2, 8'h02, 6'd0);
		send_op(OP_ADD, 32'h0000_0000, 3'd4, 8'h00, 6'd0);
		send_op(OP_ADD, 32'h1234_5678, 3'd3, 8'hA5, 6'd0);
		// bytes beyond the length do not take part in the match
		send_op(OP_CHECK, 32'hAB34_5678, 3'd3, 8'h00, 6'd0);
		send_op(OP_CHECK, 32'h1234_5678, 3'd2, 8'h00, 6'd0);
		send_op(OP_CHECK, 32'h1234_5678, 3'd0, 8'h00, 6'd0);
		send_op(OP_CHECK, 32'h1234_5678, 3'd6, 8'h00, 6'd0);
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd0);
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd3);
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd4);
		send_op(OP_READ, '1, 3'd7, 8'hFF, 6'd63);
		// remove from the front shifts the rest down
		send_op(OP_REMOVE, 32'h0000_00FF, 3'd1, 8'h00, 6'd0);
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd0);
		send_op(OP_REMOVE, 32'h0000_00FF, 3'd0, 8'h00, 6'd0);
		send_op(3'd5, '1, 3'd1, 8'h00, 6'd0);
		send_op(3'd6, '0, 3'd2, 8'h00, 6'd0);
		send_op(3'd7, '1, 3'd4, 8'hFF, 6'd63);
		send_op(OP_CLEAR, '0, 3'd0, 8'h00, 6'd0);
		send_op(OP_READ, '0, 3'd0, 8'h00, 6'd0);
		wait_drained();
	endtask

	// random traffic over a fresh pool of identifiers, adds weighted by add_pct
	task automatic run_random_items(input int n_items, input int add_pct);
		int k;
		int pick;
		int sel;
		logic [OP_W-1:0]  op;
		logic [UID_W-1:0] uid;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] idx;
		// some pool entries share their low byte with the previous one
		for (k = 0; k < POOL_SIZE; k++) begin
			if (k > 0 && $urandom_range(99) < 30)
				pool_uid[k] = pool_uid[k-1] ^ ($urandom & 32'hFFFF_FF00);
			else
				pool_uid[k] = $urandom;
			pool_len[k] = LEN_W'($urandom_range(1, 4));
		end
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(99) < add_pct)
				op = OP_ADD;
			else begin
				sel = $urandom_range(99);
				if (sel < 30)
					op = OP_REMOVE;
				else if (sel < 65)
					op = OP_CHECK;
				else if (sel < 92)
					op = OP_READ;
				else if (sel < 95)
					op = OP_CLEAR;
				else
					op = OP_W'($urandom_range(5, 7));
			end
			pick = $urandom_range(POOL_SIZE - 1);
			uid = ($urandom_range(99) < 88) ? pool_uid[pick] : $urandom;
			len = ($urandom_range(99) < 88) ? pool_len[pick] : LEN_W'($urandom_range(0, 7));
			if ($urandom_range(99) < 80)
				idx = IDX_W'($urandom_range(0, wl_count));
			else
				idx = IDX_W'($urandom_range(0, 63));
			send_op(op, uid, len, KIND_W'($urandom_range(0, 255)), idx);
		end
		wait_drained();
	endtask

	task automatic test_no_idling();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_items(100, 45);
	endtask

	// add heavy so the table fills up and overflows
	task automatic test_sender_idle();
		send_idle_pct = 79;
		recv_stall_pct = 0;
		run_random_items(100, 80);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 79;
		run_random_items(100, 40);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 13;
		recv_stall_pct = 13;
		run_random_items(100, 60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		wipe_table();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
